FILE: rtl/ifd_pkg.sv
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types and constants of the image frame deframer: the pixel entry
// that travels from the byte parser through the queue to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package ifd_pkg;

   // number of low size bits that are kept from the four size bytes
   localparam int LENGTH_BITS = 32;

   // sync mark byte, three in a row open a frame
   localparam logic [7:0] SYNC_BYTE = 8'h3C;

   // depth of the queue between parser and output stage
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // one pixel byte with its frame context
   typedef struct packed {
      logic        last_pixel;
      logic        first_pixel;
      logic [15:0] frame_height;
      logic [15:0] frame_width;
      logic [7:0]  pixel;
   } ifd_entry_type;

endpackage

`default_nettype wire

FILE: rtl/image_frame_deframer.sv
// ----------------------------------------------------------------------------
// image_frame_deframer
// Finds frames in a raw byte stream and delivers their pixel bytes with the
// frame width, height and first and last marks.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  req_*     in         one raw stream byte per transfer
//  rsp_*     out        one pixel byte with frame context per transfer
//
//  One byte is taken per clock while req_tready is high; header and sync bytes give no result.
//  A pixel byte is written into the queue, then loaded into the output register for rsp_*.
//  A four-entry queue sits between the parser and the output register;
//  req_tready drops only while that queue is full.
//  reset is synchronous and returns the parser to hunting for sync.
// ----------------------------------------------------------------------------
`default_nettype none

module image_frame_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [7:0] pixel, [23:8] frame_width,
                                         // [39:24] frame_height
   output logic [0:0]       rsp_tuser,   // [0] first_pixel
   output logic             rsp_tlast    // last_pixel
);
   import ifd_pkg::*;

   logic          byte_valid;
   logic          push_valid;
   ifd_entry_type push_entry;
   logic          queue_full;
   logic          pop_valid;
   logic          pop_ready;
   ifd_entry_type pop_entry;
   ifd_entry_type out_entry;

   // input transfer
   assign req_tready = !queue_full;
   assign byte_valid = req_tvalid && req_tready;

   ifd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (req_tdata),
      .push_entry (push_entry),
      .push_valid (push_valid)
   );

   ifd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   ifd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .out_valid (rsp_tvalid),
      .out_entry (out_entry),
      .out_ready (rsp_tready)
   );

   // result packing
   assign rsp_tdata = {out_entry.frame_height, out_entry.frame_width, out_entry.pixel};
   assign rsp_tuser = out_entry.first_pixel;
   assign rsp_tlast = out_entry.last_pixel;

endmodule

`default_nettype wire

FILE: rtl/ifd_front.sv
// ----------------------------------------------------------------------------
// ifd_front
// Byte parser: hunts for the sync mark, reads size, width and height, and
// pushes each pixel byte with its frame context into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ifd_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  byte_valid,
   input  wire logic [7:0]            byte_data,
   output ifd_pkg::ifd_entry_type     push_entry,
   output logic                       push_valid
);
   import ifd_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_SIZE   = 3'd1,
      PH_WIDTH  = 3'd2,
      PH_HEIGHT = 3'd3,
      PH_PIXELS = 3'd4
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [1:0]             sync_run_ff, sync_run_in;
   logic [1:0]             field_cnt_ff, field_cnt_in;
   logic [LENGTH_BITS-1:0] remaining_ff, remaining_in;
   logic [15:0]            width_ff, width_in;
   logic [15:0]            height_ff, height_in;
   logic                   first_pending_ff, first_pending_in;

   logic [31:0]            size_shifted;
   logic [LENGTH_BITS-1:0] size_assembled;
   logic [LENGTH_BITS-1:0] remaining_dec;

   // size byte placed at its byte lane, then cut to the kept width
   assign size_shifted   = {24'd0, byte_data} << {field_cnt_ff, 3'b000};
   assign size_assembled = ((field_cnt_ff == 2'd0) ? '0 : remaining_ff)
                           | size_shifted[LENGTH_BITS-1:0];
   assign remaining_dec  = remaining_ff - LENGTH_BITS'(1);

   // pixel entry, valid only in the pixel phase
   assign push_entry.pixel        = byte_data;
   assign push_entry.frame_width  = width_ff;
   assign push_entry.frame_height = height_ff;
   assign push_entry.first_pixel  = first_pending_ff;
   assign push_entry.last_pixel   = (remaining_ff == LENGTH_BITS'(1));
   assign push_valid              = byte_valid && (phase_ff == PH_PIXELS);

   // next state of the parser
   always_comb begin
      phase_in         = phase_ff;
      sync_run_in      = sync_run_ff;
      field_cnt_in     = field_cnt_ff;
      remaining_in     = remaining_ff;
      width_in         = width_ff;
      height_in        = height_ff;
      first_pending_in = first_pending_ff;
      if (byte_valid) begin
         case (phase_ff)
            PH_SIZE: begin
               remaining_in = size_assembled;
               if (field_cnt_ff == 2'd3) begin
                  field_cnt_in = 2'd0;
                  if (size_assembled == '0) begin
                     phase_in    = PH_HUNT;
                     sync_run_in = 2'd0;
                  end else begin
                     phase_in = PH_WIDTH;
                  end
               end else begin
                  field_cnt_in = field_cnt_ff + 2'd1;
               end
            end
            PH_WIDTH, PH_HEIGHT: begin
               if (phase_ff == PH_WIDTH) begin
                  width_in = field_cnt_ff[0] ? {byte_data, width_ff[7:0]}
                                             : {8'd0, byte_data};
               end else begin
                  height_in = field_cnt_ff[0] ? {byte_data, height_ff[7:0]}
                                              : {8'd0, byte_data};
               end
               remaining_in = remaining_dec;
               if (remaining_dec == '0) begin
                  // payload ended inside the header
                  phase_in     = PH_HUNT;
                  sync_run_in  = 2'd0;
                  field_cnt_in = 2'd0;
               end else if (!field_cnt_ff[0]) begin
                  field_cnt_in = 2'd1;
               end else begin
                  field_cnt_in = 2'd0;
                  if (phase_ff == PH_WIDTH) begin
                     phase_in = PH_HEIGHT;
                  end else begin
                     phase_in         = PH_PIXELS;
                     first_pending_in = 1'b1;
                  end
               end
            end
            PH_PIXELS: begin
               first_pending_in = 1'b0;
               remaining_in     = remaining_dec;
               if (remaining_dec == '0) begin
                  phase_in     = PH_HUNT;
                  sync_run_in  = 2'd0;
                  field_cnt_in = 2'd0;
               end
            end
            default: begin
               // hunting, also taken by unused phase codes
               if (byte_data == SYNC_BYTE) begin
                  if (sync_run_ff >= 2'd2) begin
                     phase_in     = PH_SIZE;
                     sync_run_in  = 2'd0;
                     field_cnt_in = 2'd0;
                     remaining_in = '0;
                  end else begin
                     sync_run_in = sync_run_ff + 2'd1;
                  end
               end else begin
                  sync_run_in = 2'd0;
               end
            end
         endcase
      end
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         sync_run_ff      <= 2'd0;
         field_cnt_ff     <= 2'd0;
         remaining_ff     <= '0;
         width_ff         <= 16'd0;
         height_ff        <= 16'd0;
         first_pending_ff <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         sync_run_ff      <= sync_run_in;
         field_cnt_ff     <= field_cnt_in;
         remaining_ff     <= remaining_in;
         width_ff         <= width_in;
         height_ff        <= height_in;
         first_pending_ff <= first_pending_in;
      end
   end

   // a sync run never reaches three without leaving the hunt
   a_sync_run_bound: assert property (@(posedge clock) disable iff (reset)
      sync_run_ff != 2'd3)
      else $error("sync run counter overran");

   // pixel phase always holds at least one byte still to come
   a_pixels_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PIXELS) |-> (remaining_ff != '0))
      else $error("pixel phase with empty payload");

   // the last pixel returns the parser to hunting
   a_last_to_hunt: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_entry.last_pixel) |=> (phase_ff == PH_HUNT))
      else $error("parser did not resume hunting after last pixel");

endmodule

`default_nettype wire

FILE: rtl/ifd_queue.sv
// ----------------------------------------------------------------------------
// ifd_queue
// Short first-in first-out queue of pixel entries between the parser and the
// output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ifd_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   input  ifd_pkg::ifd_entry_type     push_entry,
   output logic                       full,
   output logic                       pop_valid,
   output ifd_pkg::ifd_entry_type     pop_entry,
   input  wire logic                  pop_ready
);
   import ifd_pkg::*;

   ifd_entry_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full      = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_PTR_BITS+1)'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - (QUEUE_PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // fill count stays within the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   // nothing is offered into a full queue, entries would be lost
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push_valid)
      else $error("push into full queue");

   // pointers stay apart by exactly the fill count
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[QUEUE_PTR_BITS-1:0])
      else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

FILE: rtl/ifd_back.sv
// ----------------------------------------------------------------------------
// ifd_back
// Output stage: takes entries from the queue into the result register and
// holds them until the result channel takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module ifd_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pop_valid,
   input  ifd_pkg::ifd_entry_type     pop_entry,
   output logic                       pop_ready,
   output logic                       out_valid,
   output ifd_pkg::ifd_entry_type     out_entry,
   input  wire logic                  out_ready
);
   import ifd_pkg::*;

   logic          valid_ff, valid_in;
   ifd_entry_type entry_ff, entry_in;

   // load whenever the register is empty or being emptied
   assign pop_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (pop_ready) begin
         valid_in = pop_valid;
         entry_in = pop_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign out_valid = valid_ff;
   assign out_entry = entry_ff;

endmodule

`default_nettype wire
